// File: rtl/core/qlhd_pkg.sv
package qlhd_pkg;

   localparam logic [1:0] ST_PROGRESS = 2'd0;
   localparam logic [1:0] ST_DETECTED = 2'd1;
   localparam logic [1:0] ST_FAILED   = 2'd2;

   localparam logic [2:0] PH_START     = 3'd0;
   localparam logic [2:0] PH_INITIAL   = 3'd1;
   localparam logic [2:0] PH_HANDSHAKE = 3'd2;
   localparam logic [2:0] PH_DONE      = 3'd3;
   localparam logic [2:0] PH_FAILED    = 3'd4;

   localparam logic [1:0] KIND_INITIAL   = 2'd0;
   localparam logic [1:0] KIND_ZERO_RTT  = 2'd1;
   localparam logic [1:0] KIND_HANDSHAKE = 2'd2;
   localparam logic [1:0] KIND_RETRY     = 2'd3;

   localparam int FLAG_INITIAL   = 0;
   localparam int FLAG_HANDSHAKE = 1;
   localparam int FLAG_EARLY     = 2;
   localparam int FLAG_RETRY     = 3;

   localparam logic [9:0] OFFSET_MAX      = 10'd1023;
   localparam logic [7:0] LONG_HEADER_MSK = 8'hC0;
   localparam logic [1:0] KIND_MSK        = 2'h3;
   localparam logic [7:0] CID_LEN_RESET   = 8'd20;

   localparam logic CSR_MAX_CID = 1'b0;

   typedef struct packed {
      logic [2:0]  phase;
      logic [3:0]  flags;
      logic [31:0] version;
      logic [1:0]  kind;
      logic [7:0]  dest_len;
      logic [7:0]  source_len;
      logic [9:0]  offset;
      logic [7:0]  first_byte;
      logic [31:0] pkt_version;
      logic [7:0]  pkt_dest_len;
      logic [7:0]  pkt_source_len;
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] version;
      logic [1:0]  kind;
      logic [7:0]  dest_len;
      logic [7:0]  source_len;
      logic [2:0]  phase;
      logic [3:0]  flags;
   } result_type;

endpackage

// File: rtl/core/quic_long_header_detector_core.sv
// QUIC long-header detector for the UDP payload of one flow.
// Request channel: one payload byte per request (req_data_byte), with
// req_last_byte high on the final byte of each packet. Requests are taken
// at one per cycle whenever the result register is empty or being drained.
// Result channel: one result per packet, built from the last byte and shown
// on the rsp_ ports the cycle after that byte is accepted.
// Non-final bytes only update the parse state and give no result.
// Throughput: one byte per cycle while req_ready is high (state update loop).
// When the receiver stalls, the result register holds its result and
// req_ready drops until it is taken; a taken result frees the register in
// the same cycle, so back-to-back packets flow without a bubble.
// Configuration: max_cid_length at byte address 0 of the csr_ port, to be written
// by the user only while the block is idle (not enforced); reads return it.
// Reset (synchronous, active high): parse state, sticky flags and committed
// fields clear to zero, max_cid_length returns to 20 and the result register
// empties. No clearing pass is needed.
module quic_long_header_detector_core import qlhd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_version,
   output logic [1:0]  rsp_packet_kind,
   output logic [7:0]  rsp_dest_id_length,
   output logic [7:0]  rsp_source_id_length,
   output logic [2:0]  rsp_phase,
   output logic        rsp_initial_flag,
   output logic        rsp_handshake_flag,
   output logic        rsp_early_data_flag,
   output logic        rsp_retry_flag,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   state_type  state_ff;
   state_type  state_in;
   result_type res_in;
   result_type res_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] max_cid_ff;
   logic [7:0] max_cid_in;
   logic       req_fire;
   logic       csr_write;

   qlhd_judge u_judge (
      .cur       (state_ff),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .max_cid   (max_cid_ff),
      .nxt       (state_in),
      .res       (res_in)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_cid_in = max_cid_ff;
      if (csr_write && csr_paddr[2] == CSR_MAX_CID) max_cid_in = csr_pwdata[7:0];

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (req_fire && req_last_byte) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_cid_ff   <= CID_LEN_RESET;
      end else begin
         if (req_fire) state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_cid_ff   <= max_cid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_last_byte) res_ff <= res_in;
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == CSR_MAX_CID) csr_prdata = {24'd0, max_cid_ff};
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = res_ff.status;
   assign rsp_version          = res_ff.version;
   assign rsp_packet_kind      = res_ff.kind;
   assign rsp_dest_id_length   = res_ff.dest_len;
   assign rsp_source_id_length = res_ff.source_len;
   assign rsp_phase            = res_ff.phase;
   assign rsp_initial_flag     = res_ff.flags[FLAG_INITIAL];
   assign rsp_handshake_flag   = res_ff.flags[FLAG_HANDSHAKE];
   assign rsp_early_data_flag  = res_ff.flags[FLAG_EARLY];
   assign rsp_retry_flag       = res_ff.flags[FLAG_RETRY];

endmodule

// File: rtl/core/qlhd_judge.sv
module qlhd_judge import qlhd_pkg::*; (
   input  state_type  cur,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic [7:0] max_cid,
   output state_type  nxt,
   output result_type res
);

   logic [10:0] off_w;
   logic [10:0] dest_end;
   logic [10:0] source_end;
   logic [1:0]  status;

   always_comb begin
      nxt    = cur;
      status = ST_PROGRESS;
      off_w  = {1'b0, cur.offset};

      if (cur.offset == 10'd0) begin
         nxt.first_byte = data_byte;
      end else if (cur.offset <= 10'd4) begin
         nxt.pkt_version = {cur.pkt_version[23:0], data_byte};
      end else if (cur.offset == 10'd5) begin
         nxt.pkt_dest_len = data_byte;
      end else if (off_w == 11'd6 + {3'b000, cur.pkt_dest_len}) begin
         nxt.pkt_source_len = data_byte;
      end

      dest_end   = 11'd5 + {3'b000, nxt.pkt_dest_len};
      source_end = dest_end + 11'd1 + {3'b000, nxt.pkt_source_len};

      if (last_byte) begin
         nxt.offset = 10'd0;
         if (cur.phase == PH_DONE) begin
            status = ST_DETECTED;
         end else if (cur.phase == PH_FAILED) begin
            status = ST_FAILED;
         end else if (off_w < 11'd4 ||
                      (nxt.first_byte & LONG_HEADER_MSK) != LONG_HEADER_MSK) begin
            status = ST_PROGRESS;
         end else begin
            nxt.version = nxt.pkt_version;
            nxt.kind    = nxt.first_byte[5:4] & KIND_MSK;
            if (nxt.pkt_version == 32'd0) begin
               nxt.phase = PH_DONE;
               status    = ST_DETECTED;
            end else if (off_w < 11'd5) begin
               status = ST_PROGRESS;
            end else begin
               nxt.dest_len = nxt.pkt_dest_len;
               if (nxt.pkt_dest_len > max_cid || off_w < dest_end) begin
                  nxt.phase = PH_FAILED;
                  status    = ST_FAILED;
               end else if (off_w < dest_end + 11'd1) begin
                  status = ST_PROGRESS;
               end else begin
                  nxt.source_len = nxt.pkt_source_len;
                  if (nxt.pkt_source_len > max_cid || off_w < source_end) begin
                     nxt.phase = PH_FAILED;
                     status    = ST_FAILED;
                  end else begin
                     case (nxt.kind)
                        KIND_INITIAL: begin
                           nxt.flags[FLAG_INITIAL] = 1'b1;
                           if (cur.phase == PH_START) nxt.phase = PH_INITIAL;
                        end
                        KIND_HANDSHAKE: begin
                           nxt.flags[FLAG_HANDSHAKE] = 1'b1;
                           if (cur.phase == PH_INITIAL) nxt.phase = PH_HANDSHAKE;
                        end
                        KIND_ZERO_RTT: nxt.flags[FLAG_EARLY] = 1'b1;
                        default:       nxt.flags[FLAG_RETRY] = 1'b1;
                     endcase
                     if (nxt.flags[FLAG_INITIAL]) begin
                        nxt.phase = PH_DONE;
                        status    = ST_DETECTED;
                     end
                  end
               end
            end
         end
      end else if (cur.offset != OFFSET_MAX) begin
         nxt.offset = cur.offset + 10'd1;
      end

      res.status     = status;
      res.version    = nxt.version;
      res.kind       = nxt.kind;
      res.dest_len   = nxt.dest_len;
      res.source_len = nxt.source_len;
      res.phase      = nxt.phase;
      res.flags      = nxt.flags;
   end

endmodule

// File: tb/sv/tb.sv
module tb;
   import qlhd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  first;
      logic [31:0] version;
      logic [7:0]  dest_len;
      logic [7:0]  source_len;
      logic [15:0] span;
      logic        typed;
      result_type  verdict;
   } probe_row_type;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_SPARSE,
      SINK_PULSE
   } sink_style_type;

   localparam logic [2:0] MAX_CID_ADDR = {CSR_MAX_CID, 2'b00};

   localparam result_type IDLE_VERDICT = '0;
   localparam result_type FIVE_BYTE_VERDICT =
      '{ST_PROGRESS, 32'h1, KIND_ZERO_RTT, 8'd0, 8'd0, PH_START, 4'b0000};

   localparam probe_row_type PROBES [9] = '{
      '{8'h00, 32'h0,         8'd0,  8'd0,  16'd1,  1'b1, IDLE_VERDICT},
      '{8'hFF, 32'hFFFF_FFFF, 8'd0,  8'd0,  16'd4,  1'b1, IDLE_VERDICT},
      '{8'h80, 32'hFFFF_FFFF, 8'd0,  8'd0,  16'd6,  1'b1, IDLE_VERDICT},
      '{8'h7F, 32'h1,         8'd3,  8'd0,  16'd6,  1'b1, IDLE_VERDICT},
      '{8'hD0, 32'h1,         8'd0,  8'd0,  16'd5,  1'b1, FIVE_BYTE_VERDICT},
      '{8'hE0, 32'hFFFF_FFFF, 8'd3,  8'd0,  16'd9,  1'b0, IDLE_VERDICT},
      '{8'hEF, 32'h8000_0000, 8'd20, 8'd0,  16'd27, 1'b0, IDLE_VERDICT},
      '{8'hF0, 32'h0000_0100, 8'd0,  8'd20, 16'd27, 1'b0, IDLE_VERDICT},
      '{8'hDA, 32'h6B33_43CF, 8'd1,  8'd2,  16'd10, 1'b0, IDLE_VERDICT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_version;
   logic [1:0]  rsp_packet_kind;
   logic [7:0]  rsp_dest_id_length;
   logic [7:0]  rsp_source_id_length;
   logic [2:0]  rsp_phase;
   logic        rsp_initial_flag;
   logic        rsp_handshake_flag;
   logic        rsp_early_data_flag;
   logic        rsp_retry_flag;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // detector state as the block should hold it
   logic [7:0]  cid_limit = CID_LEN_RESET;
   logic [2:0]  phase_q = PH_START;
   logic [3:0]  seen_q = 4'b0000;
   logic [31:0] ver_q = 32'd0;
   logic [1:0]  kind_q = KIND_INITIAL;
   logic [7:0]  dlen_q = 8'd0;
   logic [7:0]  slen_q = 8'd0;
   logic [9:0]  offset_q = 10'd0;
   logic [7:0]  hdr_first = 8'd0;
   logic [31:0] hdr_version = 32'd0;
   logic [7:0]  hdr_dlen = 8'd0;
   logic [7:0]  hdr_slen = 8'd0;

   result_type     pending_verdicts [$];
   logic [7:0]     frame [$];
   int unsigned    faults = 0;
   int unsigned    bytes_sent = 0;
   int unsigned    burst_left = 0;
   sink_style_type sink_mode = SINK_OPEN;
   int unsigned    sink_run = 0;

   quic_long_header_detector_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_version          (rsp_version),
      .rsp_packet_kind      (rsp_packet_kind),
      .rsp_dest_id_length   (rsp_dest_id_length),
      .rsp_source_id_length (rsp_source_id_length),
      .rsp_phase            (rsp_phase),
      .rsp_initial_flag     (rsp_initial_flag),
      .rsp_handshake_flag   (rsp_handshake_flag),
      .rsp_early_data_flag  (rsp_early_data_flag),
      .rsp_retry_flag       (rsp_retry_flag),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic logic [1:0] judge_packet(input int unsigned plen);
      int unsigned src_len_pos;
      if (phase_q == PH_DONE) return ST_DETECTED;
      if (phase_q == PH_FAILED) return ST_FAILED;
      if (plen < 5) return ST_PROGRESS;
      if ((hdr_first & LONG_HEADER_MSK) != LONG_HEADER_MSK) return ST_PROGRESS;
      ver_q = hdr_version;
      kind_q = hdr_first[5:4];
      if (ver_q == 32'd0) begin
         phase_q = PH_DONE;
         return ST_DETECTED;
      end
      if (plen < 6) return ST_PROGRESS;
      dlen_q = hdr_dlen;
      if (dlen_q > cid_limit || plen < 6 + dlen_q) begin
         phase_q = PH_FAILED;
         return ST_FAILED;
      end
      src_len_pos = 6 + dlen_q;
      if (plen < src_len_pos + 1) return ST_PROGRESS;
      slen_q = hdr_slen;
      if (slen_q > cid_limit || plen < src_len_pos + 1 + slen_q) begin
         phase_q = PH_FAILED;
         return ST_FAILED;
      end
      case (kind_q)
         KIND_INITIAL: begin
            seen_q[FLAG_INITIAL] = 1'b1;
            if (phase_q == PH_START) phase_q = PH_INITIAL;
         end
         KIND_HANDSHAKE: begin
            seen_q[FLAG_HANDSHAKE] = 1'b1;
            if (phase_q == PH_INITIAL) phase_q = PH_HANDSHAKE;
         end
         KIND_ZERO_RTT: seen_q[FLAG_EARLY] = 1'b1;
         default: seen_q[FLAG_RETRY] = 1'b1;
      endcase
      if (seen_q[FLAG_INITIAL]) begin
         phase_q = PH_DONE;
         return ST_DETECTED;
      end
      return ST_PROGRESS;
   endfunction

   function automatic bit take_byte(input logic [7:0] b, input logic last,
                                    output result_type verdict);
      int unsigned off;
      off = offset_q;
      verdict = '0;
      if (off == 0) hdr_first = b;
      else if (off <= 4) hdr_version = {hdr_version[23:0], b};
      else if (off == 5) hdr_dlen = b;
      else if (off == 6 + hdr_dlen) hdr_slen = b;
      if (!last) begin
         if (offset_q != OFFSET_MAX) offset_q = offset_q + 10'd1;
         return 1'b0;
      end
      verdict.status = judge_packet(off + 1);
      offset_q = 10'd0;
      verdict.version = ver_q;
      verdict.kind = kind_q;
      verdict.dest_len = dlen_q;
      verdict.source_len = slen_q;
      verdict.phase = phase_q;
      verdict.flags = seen_q;
      return 1'b1;
   endfunction

   function automatic void build_frame(input logic [7:0] first, input logic [31:0] version,
                                       input logic [7:0] dlen, input logic [7:0] slen,
                                       input int len);
      frame.delete();
      frame.push_back(first);
      for (int i = 3; i >= 0; i--) frame.push_back(version[8*i +: 8]);
      frame.push_back(dlen);
      repeat (dlen) frame.push_back(8'($urandom));
      frame.push_back(slen);
      repeat (slen) frame.push_back(8'($urandom));
      while (frame.size() < len) frame.push_back(8'($urandom));
      while (frame.size() > len) void'(frame.pop_back());
   endfunction

   task automatic note(input string what, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         faults++;
         if (faults <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                            input result_type typed_verdict);
      result_type verdict;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      bytes_sent++;
      if (take_byte(b, last, verdict))
         pending_verdicts.push_back(typed ? typed_verdict : verdict);
   endtask

   task automatic send_frame(input bit typed, input result_type typed_verdict);
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1, typed, typed_verdict);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   task automatic set_cid_limit(input logic [7:0] limit);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= MAX_CID_ADDR;
      csr_pwdata <= {24'($urandom), limit};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cid_limit = limit;
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      note("max_cid_length", limit, csr_prdata[7:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic random_frame(input bit allow_end);
      logic [7:0]  first;
      logic [7:0]  dl;
      logic [7:0]  sl;
      logic [31:0] ver;
      int          cap;
      int          span;
      int          len;
      cap = (cid_limit > 8) ? 8 : cid_limit;
      span = (cid_limit > 40) ? 40 : cid_limit;
      first = 8'hC0 | 8'($urandom_range(0, 63));
      if (first[5:4] == KIND_INITIAL) first[4] = 1'b1;
      ver = $urandom;
      if (ver == 32'd0) ver = 32'd1;
      dl = 8'($urandom_range(0, cap));
      sl = 8'($urandom_range(0, cap));
      if ($urandom_range(0, 9) == 0) dl = 8'($urandom_range(0, span));
      if ($urandom_range(0, 9) == 0) sl = 8'($urandom_range(0, span));
      len = 7 + dl + sl + $urandom_range(0, 8);
      case ($urandom_range(0, allow_end ? 11 : 9))
         0, 1: begin
            first = 8'($urandom);
            len = $urandom_range(1, 4);
         end
         2: begin
            first = 8'($urandom_range(0, 191));
            len = $urandom_range(1, 40);
         end
         3: len = 5;
         4: len = 6 + dl;
         10, 11: begin
            case ($urandom_range(0, 3))
               0: begin
                  ver = 32'd0;
                  len = $urandom_range(5, len);
               end
               1: first[5:4] = KIND_INITIAL;
               2: begin
                  if (cid_limit == 8'd255 || (cid_limit != 8'd0 && $urandom_range(0, 1))) begin
                     dl = 8'($urandom_range(1, span));
                     len = $urandom_range(6, 5 + dl);
                  end else begin
                     dl = 8'($urandom_range(cid_limit + 1, 255));
                     len = 6 + $urandom_range(0, 30);
                  end
               end
               default: begin
                  if (cid_limit == 8'd255 || (cid_limit != 8'd0 && $urandom_range(0, 1))) begin
                     sl = 8'($urandom_range(1, span));
                     len = $urandom_range(7 + dl, 6 + dl + sl);
                  end else begin
                     sl = 8'($urandom_range(cid_limit + 1, 255));
                     len = 7 + dl + $urandom_range(0, 30);
                  end
               end
            endcase
         end
         default: ;
      endcase
      build_frame(first, ver, dl, sl, len);
      send_frame(1'b0, IDLE_VERDICT);
   endtask

   always @(posedge clock) begin
      if (sink_run == 0) begin
         sink_mode <= sink_style_type'($urandom_range(0, 3));
         sink_run <= $urandom_range(4, 64);
      end else begin
         sink_run <= sink_run - 1;
      end
      case (sink_mode)
         SINK_OPEN: rsp_ready <= 1'b1;
         SINK_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= 1'(sink_run >> 2);
      endcase
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result: status %0d phase %0d", rsp_status, rsp_phase);
         end else begin
            want = pending_verdicts.pop_front();
            note("status", want.status, rsp_status);
            note("version", want.version, rsp_version);
            note("packet_kind", want.kind, rsp_packet_kind);
            note("dest_id_length", want.dest_len, rsp_dest_id_length);
            note("source_id_length", want.source_len, rsp_source_id_length);
            note("phase", want.phase, rsp_phase);
            note("initial_flag", want.flags[FLAG_INITIAL], rsp_initial_flag);
            note("handshake_flag", want.flags[FLAG_HANDSHAKE], rsp_handshake_flag);
            note("early_data_flag", want.flags[FLAG_EARLY], rsp_early_data_flag);
            note("retry_flag", want.flags[FLAG_RETRY], rsp_retry_flag);
         end
      end
   end

   initial begin
      #12_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      int unsigned phase_end;
      logic [7:0]  limits [4];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (PROBES[i]) begin
         build_frame(PROBES[i].first, PROBES[i].version, PROBES[i].dest_len,
                     PROBES[i].source_len, PROBES[i].span);
         send_frame(PROBES[i].typed, PROBES[i].verdict);
      end
      limits = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), 8'($urandom)};
      foreach (limits[p]) begin
         hold_until_drained();
         repeat (3) @(posedge clock);
         set_cid_limit(limits[p]);
         if (p == 1) begin
            // run the byte offset into saturation
            build_frame(8'hD0 | 8'($urandom_range(0, 15)), 32'($urandom) | 32'h1, 8'd4,
                        8'd4, 1030 + $urandom_range(0, 40));
            send_frame(1'b0, IDLE_VERDICT);
         end
         phase_end = bytes_sent + 90;
         while (bytes_sent < phase_end) random_frame(p == 3);
      end
      hold_until_drained();
      repeat (4) @(posedge clock);
      if (faults == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// File: quic_long_header_detector_core.f
rtl/core/qlhd_pkg.sv
rtl/core/qlhd_judge.sv
rtl/core/quic_long_header_detector_core.sv
tb/sv/tb.sv
